// ===== sv/eabz_pkg.sv =====
// eabz_pkg: constants, types and tables for the elliptic arc to bezier unit
// no dependencies
package eabz_pkg;

  localparam int CordicSteps = 24;
  localparam int StepW = 5;

  localparam logic signed [35:0] TurnQ26 = 36'sd421657428;
  localparam logic signed [35:0] HalfQ26 = 36'sd210828714;
  localparam logic signed [35:0] QuarterQ26 = 36'sd105414357;
  localparam logic signed [35:0] ThreeQ26 = 36'sd316243071;
  localparam logic signed [39:0] TurnQ30 = 40'sd6746518852;
  localparam logic signed [39:0] HalfQ30 = 40'sd3373259426;
  localparam logic signed [39:0] QuarterQ30 = 40'sd1686629713;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;
  // ceil(2^33 / 3): exact divide by three for operands below 2^32
  localparam logic signed [33:0] RecipThree = 34'sd2863311531;

  function automatic logic signed [31:0] atan_lut(input logic [StepW-1:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0: v = 32'sd843314856;
      5'd1: v = 32'sd497837829;
      5'd2: v = 32'sd263043836;
      5'd3: v = 32'sd133525158;
      5'd4: v = 32'sd67021686;
      5'd5: v = 32'sd33543515;
      5'd6: v = 32'sd16775850;
      5'd7: v = 32'sd8388437;
      5'd8: v = 32'sd4194282;
      5'd9: v = 32'sd2097149;
      5'd10: v = 32'sd1048575;
      5'd11: v = 32'sd524287;
      5'd12: v = 32'sd262143;
      5'd13: v = 32'sd131071;
      5'd14: v = 32'sd65535;
      5'd15: v = 32'sd32767;
      5'd16: v = 32'sd16383;
      5'd17: v = 32'sd8191;
      5'd18: v = 32'sd4095;
      5'd19: v = 32'sd2047;
      5'd20: v = 32'sd1023;
      5'd21: v = 32'sd511;
      5'd22: v = 32'sd255;
      5'd23: v = 32'sd127;
      5'd24: v = 32'sd63;
      5'd25: v = 32'sd31;
      5'd26: v = 32'sd15;
      5'd27: v = 32'sd7;
      5'd28: v = 32'sd3;
      5'd29: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'h7fffffff;
    if (v < -66'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

endpackage

// ===== sv/elliptic_arc_to_cubic_bezier_unit.sv =====
// elliptic_arc_to_cubic_bezier_unit: splits an elliptical arc into cubic bezier segments
// depends on eabz_pkg
//
// one item in gives one to four segments out. a single sequencer drives one
// shared cordic rotator (one micro-rotation per cycle, 24 steps), one shared
// 34x34 multiplier (one product per cycle, also used for the divide by three
// of the handle factor) and one shared shift-subtract divider (one quotient
// bit per cycle). per item the setup runs the sweep reduction, the
// quarter-sweep divide, a cordic run, the 64-bit tangent divide, the handle
// products and the start-angle cordic run. each segment then runs a 40-bit
// angle divide, a modulo reduction, a cordic run, eight products and the
// emit step, and then waits out any output stall; the input is not ready
// while an item is in work and until its final segment has been taken from
// the output register
module elliptic_arc_to_cubic_bezier_unit
  import eabz_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic        [30:0] in_radius_x,
  input  logic        [30:0] in_radius_y,
  input  logic signed [31:0] in_start_angle,
  input  logic signed [31:0] in_end_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_p0_x,
  output logic signed [31:0] out_p0_y,
  output logic signed [31:0] out_p1_x,
  output logic signed [31:0] out_p1_y,
  output logic signed [31:0] out_p2_x,
  output logic signed [31:0] out_p2_y,
  output logic signed [31:0] out_p3_x,
  output logic signed [31:0] out_p3_y,
  output logic        [1:0]  out_segment_index,
  output logic               out_last
);

  typedef enum logic [4:0] {
    S_IDLE, S_SWEEP, S_MOD26, S_COUNT, S_QDIV, S_QDIVW,
    S_CMOD, S_CMODW, S_CFOLD, S_CROT,
    S_TDIV, S_TDIVW, S_K, S_HX, S_HY,
    S_ADIV, S_ADIVW, S_PROD, S_EMIT, S_WAIT
  } state_t;

  // cordic use tags
  typedef enum logic [1:0] {U_TAN, U_START, U_SEG} use_t;

  state_t state_r;
  use_t use_r;

  logic               ccw_r;
  logic signed [31:0] cx_r, cy_r;
  logic        [30:0] rx_r, ry_r;
  logic signed [31:0] st_r, en_r;
  logic signed [35:0] d_r;
  logic        [2:0]  n_r;
  logic        [1:0]  seg_r;
  logic signed [33:0] k_r, hx_r, hy_r;
  logic signed [33:0] c1_r, s1_r, c2_r, s2_r;

  // shared divider: unsigned magnitude, restoring, one bit per cycle
  logic [63:0] dv_num_r;
  logic [63:0] dv_rem_r;
  logic [63:0] dv_den_r;
  logic [6:0]  dv_cnt_r;
  logic        dv_neg_r;
  logic [64:0] dv_trial;
  assign dv_trial = {dv_rem_r, dv_num_r[63]} - {1'b0, dv_den_r};

  // cordic
  logic signed [39:0] cz_r;
  logic signed [33:0] cxv_r, cyv_r;
  logic [StepW-1:0]   ci_r;
  logic               flip_r;

  // multiplier
  logic signed [33:0] ma, mb;
  logic signed [67:0] mprod;
  logic signed [35:0] mres;
  assign mprod = ma * mb;
  assign mres = 36'(mprod >>> 30);

  logic [2:0]         pi_r;
  logic signed [35:0] x0_r, y0_r, x3_r, y3_r;
  logic signed [39:0] ang_r;

  logic [35:0] m26;
  assign m26 = d_r[35] ? 36'(-d_r) : d_r;

  logic signed [35:0] sd;
  assign sd = ccw_r ? d_r : -d_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      S_K: begin ma = (k_r[33] ? -k_r : k_r) <<< 2; mb = RecipThree; end
      S_HX: begin ma = 34'(rx_r); mb = k_r; end
      S_HY: begin ma = 34'(ry_r); mb = k_r; end
      S_PROD: begin
        case (pi_r)
          3'd0: begin ma = 34'(rx_r); mb = c2_r; end
          3'd1: begin ma = 34'(ry_r); mb = s2_r; end
          3'd2: begin ma = 34'(rx_r); mb = c1_r; end
          3'd3: begin ma = 34'(ry_r); mb = s1_r; end
          3'd4: begin ma = hx_r; mb = s1_r; end
          3'd5: begin ma = hy_r; mb = c1_r; end
          3'd6: begin ma = hx_r; mb = s2_r; end
          default: begin ma = hy_r; mb = c2_r; end
        endcase
      end
      default: ;
    endcase
  end

  // sweep times segment number times 16, by shifts and one add
  logic signed [39:0] sd40;
  logic signed [39:0] seg_num;
  assign sd40 = 40'(sd);
  assign seg_num = (seg_r == 2'd3) ? (sd40 <<< 6) :
                   (seg_r == 2'd2) ? ((sd40 <<< 5) + (sd40 <<< 4)) :
                   (seg_r == 2'd1) ? (sd40 <<< 5) : (sd40 <<< 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ccw_r <= ~in_action;
            cx_r <= in_center_x; cy_r <= in_center_y;
            rx_r <= in_radius_x; ry_r <= in_radius_y;
            st_r <= in_start_angle; en_r <= in_end_angle;
            state_r <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (ccw_r) begin
            d_r <= 36'(en_r) - 36'(st_r);
            state_r <= S_MOD26;
          end else begin
            logic signed [35:0] dd;
            dd = 36'(st_r) - 36'(en_r);
            if (dd > TurnQ26 || dd < -TurnQ26) d_r <= TurnQ26;
            else if (dd < 0) d_r <= dd + TurnQ26;
            else d_r <= dd;
            state_r <= S_COUNT;
          end
        end
        S_MOD26: begin
          // magnitude above a turn: move a turn toward zero (subtract or add); at most 10 passes
          if (d_r > TurnQ26) d_r <= d_r - TurnQ26;
          else if (d_r < -TurnQ26) d_r <= d_r + TurnQ26;
          else state_r <= S_COUNT;
        end
        S_COUNT: begin
          if ($signed(m26) > ThreeQ26) n_r <= 3'd4;
          else if ($signed(m26) > HalfQ26) n_r <= 3'd3;
          else if ($signed(m26) > QuarterQ26) n_r <= 3'd2;
          else n_r <= 3'd1;
          state_r <= S_QDIV;
        end
        S_QDIV: begin
          // quarter segment sweep in q2.30 is (sd*4)/n
          dv_neg_r <= sd[35];
          dv_num_r <= 64'(sd[35] ? 38'(-sd) * 38'sd4 : 38'(sd) * 38'sd4);
          dv_den_r <= 64'(n_r);
          dv_rem_r <= '0;
          dv_cnt_r <= 7'd64;
          use_r <= U_TAN;
          state_r <= S_QDIVW;
        end
        S_QDIVW, S_TDIVW, S_ADIVW: begin
          if (dv_cnt_r != 7'd0) begin
            if (!dv_trial[64]) dv_rem_r <= dv_trial[63:0];
            else dv_rem_r <= {dv_rem_r[62:0], dv_num_r[63]};
            dv_num_r <= {dv_num_r[62:0], ~dv_trial[64]};
            dv_cnt_r <= dv_cnt_r - 7'd1;
          end else begin
            logic signed [63:0] qv;
            qv = dv_neg_r ? -$signed(dv_num_r) : $signed(dv_num_r);
            if (state_r == S_QDIVW) begin
              ang_r <= 40'(qv);
              state_r <= S_CMOD;
            end else if (state_r == S_TDIVW) begin
              k_r <= 34'(qv);
              state_r <= S_K;
            end else begin
              ang_r <= 40'(st_r) * 40'sd16 + 40'(qv);
              use_r <= U_SEG;
              state_r <= S_CMOD;
            end
          end
        end
        S_CMOD: begin
          // reduce modulo a turn by repeated subtract or add; angles stay within a few turns
          if (ang_r > HalfQ30) ang_r <= ang_r - TurnQ30;
          else if (ang_r <= -HalfQ30) ang_r <= ang_r + TurnQ30;
          else state_r <= S_CFOLD;
        end
        S_CFOLD: begin
          if (ang_r > QuarterQ30) begin
            cz_r <= ang_r - HalfQ30; flip_r <= 1'b1;
          end else if (ang_r < -QuarterQ30) begin
            cz_r <= ang_r + HalfQ30; flip_r <= 1'b1;
          end else begin
            cz_r <= ang_r; flip_r <= 1'b0;
          end
          cxv_r <= GainQ30;
          cyv_r <= '0;
          ci_r <= '0;
          state_r <= S_CROT;
        end
        S_CROT: begin
          if (ci_r != StepW'(CordicSteps)) begin
            if (!cz_r[39]) begin
              cxv_r <= cxv_r - (cyv_r >>> ci_r);
              cyv_r <= cyv_r + (cxv_r >>> ci_r);
              cz_r <= cz_r - 40'(atan_lut(ci_r));
            end else begin
              cxv_r <= cxv_r + (cyv_r >>> ci_r);
              cyv_r <= cyv_r - (cxv_r >>> ci_r);
              cz_r <= cz_r + 40'(atan_lut(ci_r));
            end
            ci_r <= ci_r + StepW'(1);
          end else begin
            logic signed [33:0] cc, ss;
            cc = flip_r ? -cxv_r : cxv_r;
            ss = flip_r ? -cyv_r : cyv_r;
            unique case (use_r)
              U_TAN: begin
                c2_r <= cc; s2_r <= ss;
                state_r <= S_TDIV;
              end
              U_START: begin
                c1_r <= cc; s1_r <= ss;
                seg_r <= '0;
                state_r <= S_ADIV;
              end
              default: begin
                c2_r <= cc; s2_r <= ss;
                pi_r <= '0;
                state_r <= S_PROD;
              end
            endcase
          end
        end
        S_TDIV: begin
          if (c2_r > 0) begin
            dv_neg_r <= s2_r[33];
            dv_num_r <= 64'(s2_r[33] ? -s2_r : s2_r) << 30;
            dv_den_r <= 64'(c2_r);
          end else begin
            dv_neg_r <= 1'b0;
            dv_num_r <= '0;
            dv_den_r <= 64'd1;
          end
          dv_rem_r <= '0;
          dv_cnt_r <= 7'd64;
          state_r <= S_TDIVW;
        end
        S_K: begin
          // k = (4t)/3 by reciprocal multiply, truncated toward zero
          k_r <= k_r[33] ? -34'(mprod >>> 33) : 34'(mprod >>> 33);
          state_r <= S_HX;
        end
        S_HX: begin
          hx_r <= 34'(mres);
          state_r <= S_HY;
        end
        S_HY: begin
          hy_r <= 34'(mres);
          ang_r <= 40'(st_r) * 40'sd16;
          use_r <= U_START;
          state_r <= S_CMOD;
        end
        S_ADIV: begin
          dv_neg_r <= seg_num[39];
          dv_num_r <= 64'(seg_num[39] ? -seg_num : seg_num);
          dv_den_r <= 64'(n_r);
          dv_rem_r <= '0;
          dv_cnt_r <= 7'd64;
          state_r <= S_ADIVW;
        end
        S_PROD: begin
          case (pi_r)
            3'd0: x3_r <= 36'(cx_r) + mres;
            3'd1: y3_r <= 36'(cy_r) + mres;
            3'd2: x0_r <= 36'(cx_r) + mres;
            3'd3: y0_r <= 36'(cy_r) + mres;
            3'd4: out_p1_x <= sat32(66'(x0_r) - 66'(mres));
            3'd5: out_p1_y <= sat32(66'(y0_r) + 66'(mres));
            3'd6: out_p2_x <= sat32(66'(x3_r) + 66'(mres));
            default: out_p2_y <= sat32(66'(y3_r) - 66'(mres));
          endcase
          pi_r <= pi_r + 3'd1;
          if (pi_r == 3'd7) state_r <= S_EMIT;
        end
        S_EMIT: begin
          out_p0_x <= sat32(66'(x0_r));
          out_p0_y <= sat32(66'(y0_r));
          out_p3_x <= sat32(66'(x3_r));
          out_p3_y <= sat32(66'(y3_r));
          out_segment_index <= seg_r;
          out_last <= ({1'b0, seg_r} + 3'd1 == n_r);
          out_valid <= 1'b1;
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            c1_r <= c2_r; s1_r <= s2_r;
            if (out_last) state_r <= S_IDLE;
            else begin
              seg_r <= seg_r + 2'd1;
              state_r <= S_ADIV;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> state_r == S_WAIT)
    else $error("output valid outside wait");
  assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !out_valid)
    else $error("input ready while a segment is pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> ({1'b0, out_segment_index} + 3'd1 == n_r))
    else $error("last flag on wrong segment");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CROT) |-> (n_r != 3'd0 || use_r == U_TAN))
    else $error("cordic run without segment count");

endmodule
